### rtl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sida_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int MAX_DIGITS  = 10;
   localparam int POS_W       = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // multiples k * 10^p, wide enough for 9 * 10^9
   typedef logic [MAX_DIGITS-1:0][9:0][33:0] mult_table_type;

   function automatic mult_table_type build_multiples();
      mult_table_type t;
      logic [33:0]    p10;
      p10 = 34'd1;
      for (int p = 0; p < MAX_DIGITS; p++) begin
         for (int k = 0; k < 10; k++) begin
            t[p][k] = 34'(k) * p10;
         end
         p10 = 34'(p10 * 34'd10);
      end
      return t;
   endfunction

   localparam mult_table_type MULTIPLES = build_multiples();

   typedef struct packed {
      logic              neg;
      logic [31:0]       mag;
      logic [POS_W-1:0]  ndig;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SIGN,
      BK_DIGIT
   } back_state_type;

endpackage

### rtl/sida_front.sv
// ----------------------------------------------------------------------------
// sida_front
// Takes input transactions, forms sign, magnitude and digit count.
// ----------------------------------------------------------------------------
module sida_front (
   input  logic                    req_push,
   input  logic signed [31:0]      req_value,
   input  sida_pkg::queue_status_type q_status,
   output logic                    req_full,
   output logic                    q_push,
   output sida_pkg::item_type      q_item
);

   logic        neg;
   logic [31:0] raw;
   logic [31:0] mag;
   logic [sida_pkg::POS_W-1:0] ndig;

   always_comb begin
      raw  = $unsigned(req_value);
      neg  = raw[31];
      mag  = neg ? (32'd0 - raw) : raw;
      ndig = sida_pkg::POS_W'(1);
      for (int p = 1; p < sida_pkg::MAX_DIGITS; p++) begin
         if ({2'b00, mag} >= sida_pkg::MULTIPLES[p][1]) begin
            ndig = sida_pkg::POS_W'(p + 1);
         end
      end
   end

   assign req_full    = q_status.full;
   assign q_push      = req_push && !q_status.full;
   assign q_item.neg  = neg;
   assign q_item.mag  = mag;
   assign q_item.ndig = ndig;

endmodule

### rtl/sida_queue.sv
// ----------------------------------------------------------------------------
// sida_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module sida_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sida_pkg::item_type         push_item,
   input  logic                       pop,
   output sida_pkg::item_type         head_item,
   output sida_pkg::queue_status_type status
);

   sida_pkg::item_type entries_ff [sida_pkg::QUEUE_DEPTH];
   logic [sida_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sida_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sida_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   localparam logic [sida_pkg::QUEUE_AW-1:0] LAST_PTR =
      sida_pkg::QUEUE_AW'(sida_pkg::QUEUE_DEPTH - 1);
   localparam logic [sida_pkg::QUEUE_CW-1:0] FULL_COUNT =
      sida_pkg::QUEUE_CW'(sida_pkg::QUEUE_DEPTH);

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_COUNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/sida_back.sv
// ----------------------------------------------------------------------------
// sida_back
// Emits one item's sign and digits, most significant first, one per unstalled cycle.
// ----------------------------------------------------------------------------
module sida_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sida_pkg::item_type         head_item,
   input  sida_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [7:0]                 rsp_text_char,
   output logic                       rsp_last
);

   sida_pkg::back_state_type state_ff, state_in;
   logic [31:0]                rem_ff, rem_in;
   logic [sida_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic        can_emit;
   logic        emit;
   logic [3:0]  digit;
   logic [33:0] sub;
   logic [7:0]  emit_char;
   logic        emit_last;

   assign can_emit = !out_valid_ff || rsp_pop;

   // digit at the current position by parallel compare against its multiples
   always_comb begin
      digit = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if ({2'b00, rem_ff} >= sida_pkg::MULTIPLES[pos_ff][k]) begin
            digit = 4'(k);
         end
      end
      sub = sida_pkg::MULTIPLES[pos_ff][digit];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = head_item.neg ? sida_pkg::BK_SIGN : sida_pkg::BK_DIGIT;
            end
         end
         sida_pkg::BK_SIGN: begin
            if (can_emit) begin
               state_in = sida_pkg::BK_DIGIT;
            end
         end
         sida_pkg::BK_DIGIT: begin
            if (can_emit && pos_ff == '0) begin
               state_in = sida_pkg::BK_IDLE;
            end
         end
         default: state_in = sida_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_char = sida_pkg::CHAR_ZERO + {4'b0000, digit};
      emit_last = 1'b0;
      unique case (state_ff)
         sida_pkg::BK_IDLE: begin
            q_pop = !q_status.empty;
         end
         sida_pkg::BK_SIGN: begin
            emit      = can_emit;
            emit_char = sida_pkg::CHAR_MINUS;
         end
         sida_pkg::BK_DIGIT: begin
            emit      = can_emit;
            emit_last = (pos_ff == '0);
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      pos_in = pos_ff;
      if (q_pop) begin
         rem_in = head_item.mag;
         pos_in = head_item.ndig - 1'b1;
      end else if (emit && state_ff == sida_pkg::BK_DIGIT) begin
         rem_in = rem_ff - sub[31:0];
         pos_in = pos_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = emit_char;
         out_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sida_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_text_char = out_char_ff;
   assign rsp_last      = out_last_ff;

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII characters, sign first, last flagged.
// ----------------------------------------------------------------------------
// The first character passes the queue, the back-end load and the output
// register. The back end loads an item, then emits its 1 to 11 characters
// one at a time, stalling while output is held, before loading the next item.
// A two-entry queue lets the input side run ahead of the character output.
// Reset clears queue pointers and count, back-end state and the output valid flag.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic signed [31:0] req_value,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_text_char,
   output logic               rsp_last
);

   sida_pkg::queue_status_type q_status;
   sida_pkg::item_type         q_item;
   sida_pkg::item_type         head_item;
   logic                       q_push;
   logic                       q_pop;

   sida_front u_front (
      .req_push  (req_push),
      .req_value (req_value),
      .q_status  (q_status),
      .req_full  (req_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   sida_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   sida_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_text_char (rsp_text_char),
      .rsp_last      (rsp_last)
   );

   a_push_fills_queue : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !q_status.empty)
      else $error("accepted transaction not held in queue");

   a_char_legal : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_text_char == sida_pkg::CHAR_MINUS ||
                      (rsp_text_char >= sida_pkg::CHAR_ZERO &&
                       rsp_text_char <= sida_pkg::CHAR_ZERO + 8'd9)))
      else $error("illegal output character");

   a_last_is_digit : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> rsp_text_char != sida_pkg::CHAR_MINUS)
      else $error("sign flagged as final character");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("output not empty after reset");

endmodule
